@@ sv/fpfmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfmd_pkg
// Shared types, constants and helper functions of the fiber pair flipped
// maximum distance block.
// ----------------------------------------------------------------------------
package fpfmd_pkg;

    localparam int MAX_POINTS = 32;
    localparam int COORD_BITS = 16;

    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int N_BITS     = $clog2(MAX_POINTS + 1);
    localparam int PIDX_BITS  = 5;
    localparam int CNT_BITS   = 6;
    localparam int DIST_BITS  = 34;
    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;

    localparam logic [CNT_BITS-1:0]  POINT_COUNT_RESET = CNT_BITS'(21);
    localparam logic [DIST_BITS-1:0] DIST_MAX          = '1;

    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    typedef enum logic {
        OP_STORE   = 1'b0,
        OP_COMPARE = 1'b1
    } op_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        udiff_t;
    typedef logic [SQ_BITS-1:0]           sq_t;
    typedef logic [IDX_BITS-1:0]          idx_t;
    typedef logic [DIST_BITS-1:0]         dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    typedef struct packed {
        udiff_t x;
        udiff_t y;
        udiff_t z;
    } diff3_t;

    typedef struct packed {
        sq_t x;
        sq_t y;
        sq_t z;
    } sq3_t;

    // one queued item after classification
    typedef struct packed {
        op_t    op;
        idx_t   addr_direct;
        idx_t   addr_flip;
        logic   first;
        logic   last;
        point_t point;
    } cmd_t;

    function automatic udiff_t abs_diff(input coord_t a, input coord_t b);
        logic signed [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (d[COORD_BITS]) begin
            return COORD_BITS'(-d);
        end
        return COORD_BITS'(d);
    endfunction

    function automatic sq_t square(input udiff_t a);
        return SQ_BITS'(a) * SQ_BITS'(a);
    endfunction

    function automatic dist_t sat_dist(input logic [SUM_BITS-1:0] s);
        if ({{DIST_BITS{1'b0}}, s} > {{SUM_BITS{1'b0}}, DIST_MAX}) begin
            return DIST_MAX;
        end
        return DIST_BITS'(s);
    endfunction

endpackage

@@ sv/fiber_pair_flip_max_distance_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fiber_pair_flip_max_distance_top
// Flipped maximum squared point distance between a reference fiber and a
// candidate fiber, points streamed in one at a time.
// ----------------------------------------------------------------------------
// Usage: write the point count on the cfg channel while the block is idle,
// send the reference fiber as store items (op 0, any order), then the
// candidate fiber as compare items (op 1) with index 0..N-1. The compare at
// index N-1 returns min(max direct, max flipped) squared distance on the m_
// channel; every other item returns nothing. Compares at index N or above
// are dropped.
// Throughput: one item per cycle while the receiver does not stall; each
// compare item passes the queue, a two-read-port reference memory and a
// five-stage distance pipeline that ends in the result register.
// Reset clears the queue, pipeline and both maxima and sets the point count
// to 21; the reference store is not cleared. When the receiver stalls the
// back pipeline holds, the four-entry queue fills and s_ready drops once it
// is full; the cfg channel is always ready.
// ----------------------------------------------------------------------------
module fiber_pair_flip_max_distance_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fpfmd_pkg::CNT_BITS-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [fpfmd_pkg::PIDX_BITS-1:0]  s_point_index,
    input  logic signed [15:0]               s_coord_x,
    input  logic signed [15:0]               s_coord_y,
    input  logic signed [15:0]               s_coord_z,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fpfmd_pkg::DIST_BITS-1:0]  m_squared_distance
);
    import fpfmd_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    fpfmd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_point_index (s_point_index),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .push_valid    (push_valid),
        .push_cmd      (push_cmd),
        .push_ready    (push_ready)
    );

    fpfmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_cmd    (push_cmd),
        .in_ready  (push_ready),
        .out_valid (pop_valid),
        .out_cmd   (pop_cmd),
        .out_ready (pop_ready)
    );

    fpfmd_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd_valid          (pop_valid),
        .cmd                (pop_cmd),
        .cmd_ready          (pop_ready),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_squared_distance (m_squared_distance)
    );

endmodule

@@ sv/fpfmd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfmd_front
// Holds the point count register, classifies incoming items and pushes the
// ones that do work into the command queue.
// ----------------------------------------------------------------------------
module fpfmd_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fpfmd_pkg::CNT_BITS-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [fpfmd_pkg::PIDX_BITS-1:0] s_point_index,
    input  logic signed [15:0]             s_coord_x,
    input  logic signed [15:0]             s_coord_y,
    input  logic signed [15:0]             s_coord_z,
    output logic                           push_valid,
    output fpfmd_pkg::cmd_t                push_cmd,
    input  logic                           push_ready
);
    import fpfmd_pkg::*;

    logic [CNT_BITS-1:0] point_count_reg;
    logic [N_BITS-1:0]   n_eff;
    logic [N_BITS-1:0]   n_minus1;
    logic [N_BITS-1:0]   flip_full;
    logic [N_BITS-1:0]   k_wide;
    op_t                 op;
    logic                keep;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= POINT_COUNT_RESET;
        end else if (cfg_valid) begin
            point_count_reg <= cfg_data;
        end
    end

    always_comb begin
        op = op_t'(s_op);
        // clamp point count to 1..MAX_POINTS
        if (int'(point_count_reg) > MAX_POINTS) begin
            n_eff = N_BITS'(MAX_POINTS);
        end else if (point_count_reg == '0) begin
            n_eff = N_BITS'(1);
        end else begin
            n_eff = N_BITS'(point_count_reg);
        end
        n_minus1  = n_eff - N_BITS'(1);
        k_wide    = N_BITS'(s_point_index);
        flip_full = n_minus1 - k_wide;

        unique case (op)
            OP_STORE:   keep = int'(s_point_index) < MAX_POINTS;
            OP_COMPARE: keep = int'(s_point_index) < int'(n_eff);
            default:    keep = 1'b0;
        endcase

        push_cmd.op          = op;
        push_cmd.addr_direct = IDX_BITS'(s_point_index);
        push_cmd.addr_flip   = IDX_BITS'(flip_full);
        push_cmd.first       = (s_point_index == '0);
        push_cmd.last        = (k_wide == n_minus1);
        push_cmd.point.x     = s_coord_x[COORD_BITS-1:0];
        push_cmd.point.y     = s_coord_y[COORD_BITS-1:0];
        push_cmd.point.z     = s_coord_z[COORD_BITS-1:0];
    end

    // ignored items are accepted and dropped here
    assign s_ready    = push_ready;
    assign push_valid = s_valid && keep;

endmodule

@@ sv/fpfmd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfmd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module fpfmd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  fpfmd_pkg::cmd_t in_cmd,
    output logic            in_ready,
    output logic            out_valid,
    output fpfmd_pkg::cmd_t out_cmd,
    input  logic            out_ready
);
    import fpfmd_pkg::*;

    cmd_t                 q_mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic [QPTR_BITS:0]   count_next;
    logic                 push;
    logic                 pop;

    assign in_ready  = int'(count_reg) < QDEPTH;
    assign out_valid = count_reg != '0;
    assign out_cmd   = q_mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ sv/fpfmd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfmd_back
// Reference point store and distance pipeline: memory read, absolute
// differences, squares, sums, running maxima and the result register.
// ----------------------------------------------------------------------------
module fpfmd_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cmd_valid,
    input  fpfmd_pkg::cmd_t                  cmd,
    output logic                             cmd_ready,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [fpfmd_pkg::DIST_BITS-1:0]  m_squared_distance
);
    import fpfmd_pkg::*;

    point_t ref_mem [MAX_POINTS];

    logic   adv;
    logic   pop;

    // stage 1: memory read
    logic   s1_valid_reg;
    logic   s1_first_reg;
    logic   s1_last_reg;
    point_t s1_point_reg;
    point_t rd_direct_reg;
    point_t rd_flip_reg;

    // stage 2: absolute differences
    logic   s2_valid_reg;
    logic   s2_first_reg;
    logic   s2_last_reg;
    diff3_t s2_dd_reg;
    diff3_t s2_df_reg;

    // stage 3: squares
    logic   s3_valid_reg;
    logic   s3_first_reg;
    logic   s3_last_reg;
    sq3_t   s3_dd_reg;
    sq3_t   s3_df_reg;

    // stage 4: saturated sums
    logic   s4_valid_reg;
    logic   s4_first_reg;
    logic   s4_last_reg;
    dist_t  s4_dd_reg;
    dist_t  s4_df_reg;

    dist_t  max_direct_reg;
    dist_t  max_flipped_reg;
    dist_t  max_direct_next;
    dist_t  max_flipped_next;
    dist_t  result_next;

    logic   m_valid_reg;
    dist_t  m_data_reg;

    // whole pipeline holds while the result register waits
    assign adv       = !m_valid_reg || m_ready;
    assign cmd_ready = adv;
    assign pop       = cmd_valid && adv;

    always_ff @(posedge aclk) begin
        if (pop && cmd.op == OP_STORE) begin
            ref_mem[cmd.addr_direct] <= cmd.point;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_direct_reg <= ref_mem[cmd.addr_direct];
            rd_flip_reg   <= ref_mem[cmd.addr_flip];
        end
    end

    always_comb begin
        max_direct_next  = max_direct_reg;
        max_flipped_next = max_flipped_reg;
        if (s4_first_reg || s4_dd_reg > max_direct_reg) begin
            max_direct_next = s4_dd_reg;
        end
        if (s4_first_reg || s4_df_reg > max_flipped_reg) begin
            max_flipped_next = s4_df_reg;
        end
        result_next = (max_direct_next < max_flipped_next) ? max_direct_next
                                                            : max_flipped_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            max_direct_reg  <= '0;
            max_flipped_reg <= '0;
        end else if (adv) begin
            s1_valid_reg <= pop && cmd.op == OP_COMPARE;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg && s4_last_reg;
            if (s4_valid_reg) begin
                max_direct_reg  <= max_direct_next;
                max_flipped_reg <= max_flipped_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_first_reg <= cmd.first;
            s1_last_reg  <= cmd.last;
            s1_point_reg <= cmd.point;

            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_dd_reg.x  <= abs_diff(rd_direct_reg.x, s1_point_reg.x);
            s2_dd_reg.y  <= abs_diff(rd_direct_reg.y, s1_point_reg.y);
            s2_dd_reg.z  <= abs_diff(rd_direct_reg.z, s1_point_reg.z);
            s2_df_reg.x  <= abs_diff(rd_flip_reg.x, s1_point_reg.x);
            s2_df_reg.y  <= abs_diff(rd_flip_reg.y, s1_point_reg.y);
            s2_df_reg.z  <= abs_diff(rd_flip_reg.z, s1_point_reg.z);

            s3_first_reg <= s2_first_reg;
            s3_last_reg  <= s2_last_reg;
            s3_dd_reg.x  <= square(s2_dd_reg.x);
            s3_dd_reg.y  <= square(s2_dd_reg.y);
            s3_dd_reg.z  <= square(s2_dd_reg.z);
            s3_df_reg.x  <= square(s2_df_reg.x);
            s3_df_reg.y  <= square(s2_df_reg.y);
            s3_df_reg.z  <= square(s2_df_reg.z);

            s4_first_reg <= s3_first_reg;
            s4_last_reg  <= s3_last_reg;
            s4_dd_reg    <= sat_dist(SUM_BITS'(s3_dd_reg.x) + SUM_BITS'(s3_dd_reg.y)
                                     + SUM_BITS'(s3_dd_reg.z));
            s4_df_reg    <= sat_dist(SUM_BITS'(s3_df_reg.x) + SUM_BITS'(s3_df_reg.y)
                                     + SUM_BITS'(s3_df_reg.z));

            m_data_reg   <= result_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_squared_distance = m_data_reg;

endmodule
